>>> rtl/smo_pkg.sv
package smo_pkg;

   localparam int CordicStepsDefault = 16;
   localparam int CordicStepsMax = 24;

   localparam logic [2:0] CsrDecayA = 3'd0;
   localparam logic [2:0] CsrInputGainB = 3'd1;
   localparam logic [2:0] CsrSwitchGainEta = 3'd2;
   localparam logic [2:0] CsrEmfGain = 3'd3;
   localparam logic [2:0] CsrFiltB0 = 3'd4;
   localparam logic [2:0] CsrFiltA1 = 3'd5;
   localparam logic [2:0] CsrFiltA2 = 3'd6;

   localparam logic CmdStart = 1'b0;

   localparam logic signed [31:0] SatMax = 32'sh7fffffff;
   localparam logic signed [31:0] SatMin = -32'sh80000000;

   // atan(2^-i) in 1/2^32 turns
   function automatic logic [31:0] atan_turn(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0: v = 32'd536870912;
         5'd1: v = 32'd316933406;
         5'd2: v = 32'd167458907;
         5'd3: v = 32'd85004756;
         5'd4: v = 32'd42667331;
         5'd5: v = 32'd21354465;
         5'd6: v = 32'd10679838;
         5'd7: v = 32'd5340245;
         5'd8: v = 32'd2670163;
         5'd9: v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) begin
         r = SatMax;
      end else if (v < -66'sd2147483648) begin
         r = SatMin;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/sliding_mode_back_emf_observer.sv
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    cmd, i_alpha, i_beta, u_alpha, u_beta
// rsp_      out        rsp_valid/stall    rotor_angle, rotor_speed, emf_alpha, emf_beta
// csr_      in         csr_valid/ready    csr_index, csr_data
//
// One loop sample steps a single 32x32 multiplier and one 66-bit accumulator by
// the sequencer, then the CORDIC iterates one rotation a cycle, then the speed
// filter reuses the multiplier. A start command clears the observer state and
// returns a zero result. Reset is synchronous, active high, clears the observer
// state and loads the configuration defaults. The result sits in an output
// register; req_stall is high while busy or while an undelivered result waits.
module sliding_mode_back_emf_observer #(
   parameter int CORDIC_STEPS = smo_pkg::CordicStepsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic signed [31:0] req_i_alpha,
   input  logic signed [31:0] req_i_beta,
   input  logic signed [31:0] req_u_alpha,
   input  logic signed [31:0] req_u_beta,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_rotor_angle,
   output logic signed [31:0] rsp_rotor_speed,
   output logic signed [31:0] rsp_emf_alpha,
   output logic signed [31:0] rsp_emf_beta,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam int Steps = (CORDIC_STEPS < smo_pkg::CordicStepsMax) ?
                          CORDIC_STEPS : smo_pkg::CordicStepsMax;

   typedef enum logic [2:0] {
      IDLE, AXIS, FILT, CORD_INIT, CORD_RUN, FINISH
   } state_type;

   state_type state_ff;
   logic [4:0] step_ff;      // micro-step within a phase
   logic       axis_ff;      // 0 alpha, 1 beta

   logic [16:0]        decay_a_ff;
   logic [30:0]        gain_b_ff, eta_ff;
   logic signed [31:0] emf_gain_ff, b0_ff, a1_ff, a2_ff;

   logic signed [31:0] iest_ff [2];
   logic signed [31:0] emf_ff [2];
   logic signed [31:0] rprev_ff [2];
   logic [15:0]        angprev_ff;
   logic signed [31:0] x1_ff, x2_ff, y1_ff, y2_ff;

   logic signed [31:0] meas_i_ff [2];
   logic signed [31:0] volt_ff [2];
   logic signed [31:0] r_ff;
   logic signed [65:0] acc_ff;     // sum of terms
   logic signed [31:0] opa_ff, opb_ff;
   logic signed [63:0] prod_ff;

   logic signed [33:0] cx_ff, cy_ff;
   logic [31:0]        cz_ff;
   logic [15:0]        ang_ff;

   logic               rsp_valid_ff;
   logic [15:0]        out_angle_ff;
   logic signed [31:0] out_speed_ff, out_ea_ff, out_eb_ff;

   logic signed [63:0] prod_in;
   logic signed [65:0] qterm;
   logic signed [31:0] cur_iest, cur_e, cur_rprev, cur_i, cur_u;
   logic signed [31:0] sgn_eta_r, sgn_eta_rprev;
   logic signed [33:0] cdx, cdy;
   logic [15:0]        dang;

   assign prod_in = opa_ff * opb_ff;
   assign qterm   = (66'(prod_ff) + 66'sd32768) >>> 16;

   assign cur_iest  = iest_ff[axis_ff];
   assign cur_e     = emf_ff[axis_ff];
   assign cur_rprev = rprev_ff[axis_ff];
   assign cur_i     = meas_i_ff[axis_ff];
   assign cur_u     = volt_ff[axis_ff];
   assign sgn_eta_r = (r_ff > 0) ? $signed({1'b0, eta_ff}) :
                      (r_ff < 0) ? -$signed({1'b0, eta_ff}) : 32'sd0;
   assign sgn_eta_rprev = (cur_rprev > 0) ? $signed({1'b0, eta_ff}) :
                          (cur_rprev < 0) ? -$signed({1'b0, eta_ff}) : 32'sd0;
   assign cdx = cy_ff >>> step_ff;
   assign cdy = cx_ff >>> step_ff;
   assign dang = ang_ff - angprev_ff;

   assign req_stall = (state_ff != IDLE) || rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_rotor_angle = out_angle_ff;
   assign rsp_rotor_speed = out_speed_ff;
   assign rsp_emf_alpha = out_ea_ff;
   assign rsp_emf_beta = out_eb_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         state_ff <= IDLE;
         rsp_valid_ff <= 1'b0;
         decay_a_ff <= 17'd65536;
         gain_b_ff <= '0;
         eta_ff <= '0;
         emf_gain_ff <= '0;
         b0_ff <= '0;
         a1_ff <= '0;
         a2_ff <= '0;
         for (int k = 0; k < 2; k++) begin
            iest_ff[k] <= '0;
            emf_ff[k] <= '0;
            rprev_ff[k] <= '0;
         end
         angprev_ff <= '0;
         x1_ff <= '0;
         x2_ff <= '0;
         y1_ff <= '0;
         y2_ff <= '0;
         step_ff <= '0;
         axis_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               smo_pkg::CsrDecayA: decay_a_ff <= csr_data[16:0];
               smo_pkg::CsrInputGainB: gain_b_ff <= csr_data[30:0];
               smo_pkg::CsrSwitchGainEta: eta_ff <= csr_data[30:0];
               smo_pkg::CsrEmfGain: emf_gain_ff <= csr_data;
               smo_pkg::CsrFiltB0: b0_ff <= csr_data;
               smo_pkg::CsrFiltA1: a1_ff <= csr_data;
               smo_pkg::CsrFiltA2: a2_ff <= csr_data;
               default: ;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_valid && !req_stall) begin
                  if (req_cmd == smo_pkg::CmdStart) begin
                     for (int k = 0; k < 2; k++) begin
                        iest_ff[k] <= '0;
                        emf_ff[k] <= '0;
                        rprev_ff[k] <= '0;
                     end
                     angprev_ff <= '0;
                     x1_ff <= '0;
                     x2_ff <= '0;
                     y1_ff <= '0;
                     y2_ff <= '0;
                     out_angle_ff <= '0;
                     out_speed_ff <= '0;
                     out_ea_ff <= '0;
                     out_eb_ff <= '0;
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     meas_i_ff[0] <= req_i_alpha;
                     meas_i_ff[1] <= req_i_beta;
                     volt_ff[0] <= req_u_alpha;
                     volt_ff[1] <= req_u_beta;
                     axis_ff <= 1'b0;
                     step_ff <= '0;
                     state_ff <= AXIS;
                  end
               end
            end
            // per axis: 0 r, issue a*iest; 1 issue b*sat(u-e); 2 acc a*iest;
            // 3 acc b*(u-e) - eta sgn r, issue a*rprev; 4 store iest;
            // 5 form r - a*rprev + eta sgn rprev, issue g*inner; 6 (mult); 7 store e, rprev
            AXIS: begin
               step_ff <= step_ff + 5'd1;
               case (step_ff)
                  5'd0: begin
                     r_ff <= smo_pkg::sat32(66'(cur_iest) - 66'(cur_i));
                     opa_ff <= $signed({15'd0, decay_a_ff});
                     opb_ff <= cur_iest;
                  end
                  5'd1: begin
                     opa_ff <= $signed({1'b0, gain_b_ff});
                     opb_ff <= smo_pkg::sat32(66'(cur_u) - 66'(cur_e));
                  end
                  5'd2: acc_ff <= qterm;
                  5'd3: begin
                     acc_ff <= acc_ff + qterm - 66'(sgn_eta_r);
                     opa_ff <= $signed({15'd0, decay_a_ff});
                     opb_ff <= cur_rprev;
                  end
                  5'd4: iest_ff[axis_ff] <= smo_pkg::sat32(acc_ff);
                  5'd5: begin
                     opa_ff <= emf_gain_ff;
                     opb_ff <= smo_pkg::sat32(66'(r_ff) - qterm + 66'(sgn_eta_rprev));
                  end
                  5'd6: ;
                  default: begin
                     emf_ff[axis_ff] <= smo_pkg::sat32(66'(cur_e) + qterm);
                     rprev_ff[axis_ff] <= r_ff;
                     step_ff <= '0;
                     axis_ff <= 1'b1;
                     if (axis_ff) begin
                        state_ff <= CORD_INIT;
                     end
                  end
               endcase
            end
            CORD_INIT: begin
               step_ff <= '0;
               if (emf_ff[0] < 0) begin
                  cx_ff <= -34'(emf_ff[0]);
                  cy_ff <= -34'(emf_ff[1]);
                  cz_ff <= 32'h8000_0000;
               end else begin
                  cx_ff <= 34'(emf_ff[0]);
                  cy_ff <= 34'(emf_ff[1]);
                  cz_ff <= '0;
               end
               state_ff <= CORD_RUN;
            end
            CORD_RUN: begin
               if (cy_ff >= 0) begin
                  cx_ff <= cx_ff + cdx;
                  cy_ff <= cy_ff - cdy;
                  cz_ff <= cz_ff + smo_pkg::atan_turn(step_ff);
               end else begin
                  cx_ff <= cx_ff - cdx;
                  cy_ff <= cy_ff + cdy;
                  cz_ff <= cz_ff - smo_pkg::atan_turn(step_ff);
               end
               step_ff <= step_ff + 5'd1;
               if (step_ff == 5'(Steps - 1)) begin
                  state_ff <= FILT;
                  step_ff <= '0;
               end
            end
            // 0 angle; 1 issue b0*sum; 2 issue a1*y1; 3 acc b0 term, issue a2*y2;
            // 4 acc a1 term; 5 acc a2 term; 6 done
            FILT: begin
               step_ff <= step_ff + 5'd1;
               case (step_ff)
                  5'd0: begin
                     if (emf_ff[0] == 0 && emf_ff[1] == 0) begin
                        ang_ff <= '0;
                     end else begin
                        ang_ff <= 16'((cz_ff + 32'h8000) >> 16);
                     end
                  end
                  5'd1: begin
                     opa_ff <= b0_ff;
                     opb_ff <= smo_pkg::sat32(66'($signed(dang)) + 66'(x1_ff) * 2
                                              + 66'(x2_ff));
                  end
                  5'd2: begin
                     opa_ff <= a1_ff;
                     opb_ff <= y1_ff;
                  end
                  5'd3: begin
                     acc_ff <= qterm;
                     opa_ff <= a2_ff;
                     opb_ff <= y2_ff;
                  end
                  5'd4: acc_ff <= acc_ff - qterm;
                  5'd5: acc_ff <= acc_ff - qterm;
                  default: begin
                     state_ff <= FINISH;
                  end
               endcase
            end
            FINISH: begin
               x2_ff <= x1_ff;
               x1_ff <= 32'($signed(dang));
               y2_ff <= y1_ff;
               y1_ff <= smo_pkg::sat32(acc_ff);
               angprev_ff <= ang_ff;
               out_speed_ff <= smo_pkg::sat32(acc_ff);
               if (smo_pkg::sat32(acc_ff) > 0) begin
                  out_angle_ff <= ang_ff - 16'd16384;
               end else if (smo_pkg::sat32(acc_ff) < 0) begin
                  out_angle_ff <= ang_ff + 16'd16384;
               end else begin
                  out_angle_ff <= ang_ff;
               end
               out_ea_ff <= emf_ff[0];
               out_eb_ff <= emf_ff[1];
               rsp_valid_ff <= 1'b1;
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

>>> rtl/smo_checker.sv
module smo_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_cmd,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_rotor_angle,
   input logic [31:0] rsp_rotor_speed
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_rotor_angle))
      else $error("result dropped under stall");

   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_cmd == smo_pkg::CmdStart
      |=> rsp_valid && rsp_rotor_speed == 32'd0 && rsp_rotor_angle == 16'd0)
      else $error("start result not zero");

   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken with result pending");

   a_busy_after_sample: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_cmd != smo_pkg::CmdStart |=> req_stall && !rsp_valid)
      else $error("sample finished too soon");

endmodule

bind sliding_mode_back_emf_observer smo_checker u_smo_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req_cmd(req_cmd),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_rotor_angle(rsp_rotor_angle),
   .rsp_rotor_speed(rsp_rotor_speed)
);
